>>> sv/bipartite_max_matching_core_macros.svh
// Assertion macros used by the checker file.
`ifndef BIPARTITE_MAX_MATCHING_CORE_MACROS_SVH
`define BIPARTITE_MAX_MATCHING_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BMM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bmm_pkg.sv
package bmm_pkg;

  localparam int ROW_W        = 64;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int NUM_LANES    = 8;
  localparam int LANE_W       = 8;
  localparam int LANE_IDX_W   = 3;
  localparam int DEF_MAX_LEFT  = 64;
  localparam int DEF_MAX_RIGHT = 64;
  localparam logic [CNT_W-1:0] RIGHT_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [ROW_W-1:0] interest_row;
    logic             last_row;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] right_index;
    logic             is_matched;
    logic [IDX_W-1:0] left_partner;
    logic [CNT_W-1:0] matched_total;
    logic             last_result;
  } result_t;

  // One lane's finding: lowest candidate bit in its slice.
  typedef struct packed {
    logic                  found;
    logic [LANE_IDX_W-1:0] idx;
  } lane_res_t;

  // Search stack frame: left vertex and the right vertex it took.
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] v;
  } frame_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROOT,
    ST_ADJ_WAIT,
    ST_SCAN,
    ST_DECIDE,
    ST_POP_WAIT,
    ST_POP,
    ST_PUSH_WAIT,
    ST_PUSH,
    ST_FLIP_A,
    ST_FLIP_W,
    ST_FLIP_B,
    ST_NEXT,
    ST_OUT_A,
    ST_OUT_W,
    ST_OUT_B
  } state_t;

endpackage

>>> sv/bmm_lane.sv
module bmm_lane
  import bmm_pkg::*;
(
  input  logic              clk,
  input  logic [LANE_W-1:0] bits,
  output lane_res_t         res
);

  lane_res_t res_next;

  // Lowest set bit of the slice
  always_comb begin
    res_next = '0;
    for (int i = LANE_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res_next.found = 1'b1;
        res_next.idx   = LANE_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

>>> sv/bmm_merge.sv
module bmm_merge
  import bmm_pkg::*;
(
  input  lane_res_t [NUM_LANES-1:0] lanes,
  output logic                      found,
  output logic [IDX_W-1:0]          v
);

  // Lowest lane with a hit wins
  always_comb begin
    found = 1'b0;
    v     = '0;
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      if (lanes[l].found) begin
        found = 1'b1;
        v     = IDX_W'(l * LANE_W) + IDX_W'(lanes[l].idx);
      end
    end
  end

endmodule

>>> sv/bipartite_max_matching_core.sv
// Maximum bipartite matching by augmenting-path search.
// Input: a command channel. A row is taken when start is high, busy low and
// fewer than MAX_LEFT rows are held; each row holds the acceptable right
// vertices of one left vertex, in order. Rows load one per cycle. The row with
// last_row set starts the search; busy stays high until the last result is out.
// Search: per left vertex the stored row is scanned by eight lanes of eight
// bits each, merged to the lowest unvisited candidate. Each scan step runs
// through ADJ_WAIT, SCAN and DECIDE; a stack push or pop adds a wait state
// and a PUSH or POP state; a found path is written back frame by frame
// through FLIP_A, FLIP_W and FLIP_B. Run time is data dependent.
// Output: one result per right vertex in use, ascending, each shown for one
// cycle with strobe high. The receiver cannot stall.
// Config: right_count is written through cfg_valid/cfg_ready, taken only
// while idle. Reset clears the row count and sets right_count to 64.
module bipartite_max_matching_core
  import bmm_pkg::*;
#(
  parameter int MAX_LEFT  = DEF_MAX_LEFT,
  parameter int MAX_RIGHT = DEF_MAX_RIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  output logic             strobe,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int LAW = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
  localparam int RAW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
  localparam int CW  = $clog2(MAX_LEFT + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]     right_count;
  logic [CNT_W-1:0]     nr;
  logic [CW-1:0]        row_cnt;
  logic [IDX_W-1:0]     u;
  logic [IDX_W-1:0]     cur_left;
  logic [CW-1:0]        depth;
  logic [LAW-1:0]       k;
  logic [IDX_W-1:0]     j;
  logic [ROW_W-1:0]     visited;
  logic [ROW_W-1:0]     nr_mask;
  logic [ROW_W-1:0]     cand;
  logic [MAX_RIGHT-1:0] pvalid;
  logic [CNT_W-1:0]     match_cnt;
  logic                 last_root;

  // Memories
  logic [ROW_W-1:0] adj [MAX_LEFT];
  logic [ROW_W-1:0] adj_q;
  logic [LAW-1:0]   adj_raddr;
  frame_t           stack [MAX_LEFT];
  frame_t           stack_q;
  logic [LAW-1:0]   stack_raddr;
  logic             stack_we;
  logic [LAW-1:0]   stack_waddr;
  frame_t           stack_wdata;
  logic [IDX_W-1:0] pl [MAX_RIGHT];
  logic [IDX_W-1:0] pl_q;
  logic [RAW-1:0]   pl_raddr;

  lane_res_t [NUM_LANES-1:0] lanes;
  logic                      found;
  logic [IDX_W-1:0]          v;
  logic                      row_take;

  assign nr = (right_count > CNT_W'(MAX_RIGHT)) ? CNT_W'(MAX_RIGHT) : right_count;
  assign last_root = (CW'(u) + CW'(1)) == row_cnt;
  assign row_take = (state == ST_IDLE) && start && (row_cnt < CW'(MAX_LEFT));

  // Right vertices in use
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      nr_mask[i] = (CNT_W'(i) < nr);
    end
  end

  assign cand = adj_q & ~visited & nr_mask;

  // Scan lanes and merge
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    bmm_lane u_lane (
      .clk  (clk),
      .bits (cand[l*LANE_W +: LANE_W]),
      .res  (lanes[l])
    );
  end

  bmm_merge u_merge (
    .lanes (lanes),
    .found (found),
    .v     (v)
  );

  // Adjacency memory
  always_ff @(posedge clk) begin
    if (row_take) begin
      adj[row_cnt[LAW-1:0]] <= item.interest_row;
    end
    adj_q <= adj[adj_raddr];
  end

  // Stack write port
  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = '0;
    stack_wdata = '0;
    case (state)
      ST_ROOT: begin
        stack_we         = 1'b1;
        stack_wdata.left = u;
      end
      ST_DECIDE: begin
        stack_we    = found;
        stack_waddr = LAW'(depth - CW'(1));
        stack_wdata = '{left: cur_left, v: v};
      end
      ST_PUSH: begin
        stack_we         = 1'b1;
        stack_waddr      = LAW'(depth);
        stack_wdata.left = pl_q;
      end
      default: begin
        stack_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack[stack_waddr] <= stack_wdata;
    end
    stack_q <= stack[stack_raddr];
  end

  // Partner memory
  always_ff @(posedge clk) begin
    if (state == ST_FLIP_B) begin
      pl[stack_q.v[RAW-1:0]] <= stack_q.left;
    end
    pl_q <= pl[pl_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (start && item.last_row) state_next = ST_INIT;
      ST_INIT:      state_next = ST_ROOT;
      ST_ROOT:      state_next = ST_ADJ_WAIT;
      ST_ADJ_WAIT:  state_next = ST_SCAN;
      ST_SCAN:      state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!found) begin
          state_next = (depth == CW'(1)) ? ST_NEXT : ST_POP_WAIT;
        end else begin
          state_next = pvalid[v[RAW-1:0]] ? ST_PUSH_WAIT : ST_FLIP_A;
        end
      end
      ST_POP_WAIT:  state_next = ST_POP;
      ST_POP:       state_next = ST_ADJ_WAIT;
      ST_PUSH_WAIT: state_next = ST_PUSH;
      ST_PUSH:      state_next = ST_ADJ_WAIT;
      ST_FLIP_A:    state_next = ST_FLIP_W;
      ST_FLIP_W:    state_next = ST_FLIP_B;
      ST_FLIP_B: begin
        state_next = (k == LAW'(depth - CW'(1))) ? ST_NEXT : ST_FLIP_A;
      end
      ST_NEXT: begin
        if (!last_root) state_next = ST_ROOT;
        else state_next = (nr == '0) ? ST_IDLE : ST_OUT_A;
      end
      ST_OUT_A:     state_next = ST_OUT_W;
      ST_OUT_W:     state_next = ST_OUT_B;
      ST_OUT_B: begin
        state_next = ((CNT_W'(j) + CNT_W'(1)) == nr) ? ST_IDLE : ST_OUT_A;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    cfg_ready = (state == ST_IDLE);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt     <= '0;
      strobe      <= 1'b0;
      match_cnt   <= '0;
      right_count <= RIGHT_COUNT_RST;
      pvalid      <= '0;
    end else begin
      strobe <= (state == ST_OUT_B);
      if (cfg_valid && cfg_ready) begin
        right_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (row_take) row_cnt <= row_cnt + CW'(1);
        end
        ST_INIT: begin
          pvalid    <= '0;
          match_cnt <= '0;
          u         <= '0;
        end
        ST_ROOT: begin
          cur_left  <= u;
          adj_raddr <= u[LAW-1:0];
          depth     <= CW'(1);
          visited   <= '0;
        end
        ST_DECIDE: begin
          if (!found) begin
            depth       <= depth - CW'(1);
            stack_raddr <= LAW'(depth - CW'(2));
          end else begin
            visited[v] <= 1'b1;
            pl_raddr   <= v[RAW-1:0];
            k          <= '0;
          end
        end
        ST_POP: begin
          cur_left  <= stack_q.left;
          adj_raddr <= stack_q.left[LAW-1:0];
        end
        ST_PUSH: begin
          cur_left  <= pl_q;
          adj_raddr <= pl_q[LAW-1:0];
          depth     <= depth + CW'(1);
        end
        ST_FLIP_A: begin
          stack_raddr <= k;
        end
        ST_FLIP_B: begin
          pvalid[stack_q.v[RAW-1:0]] <= 1'b1;
          if (k == LAW'(depth - CW'(1))) match_cnt <= match_cnt + CNT_W'(1);
          else k <= k + LAW'(1);
        end
        ST_NEXT: begin
          if (last_root) begin
            row_cnt <= '0;
            j       <= '0;
          end else begin
            u <= u + IDX_W'(1);
          end
        end
        ST_OUT_A: begin
          pl_raddr <= j[RAW-1:0];
        end
        ST_OUT_B: begin
          result.right_index   <= j;
          result.is_matched    <= pvalid[j[RAW-1:0]];
          result.left_partner  <= pvalid[j[RAW-1:0]] ? pl_q : '0;
          result.matched_total <= match_cnt;
          result.last_result   <= (CNT_W'(j) + CNT_W'(1)) == nr;
          j                    <= j + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/bmm_checker.sv
`include "bipartite_max_matching_core_macros.svh"

module bmm_checker
  import bmm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input in_item_t item,
  input logic     strobe,
  input result_t  result,
  input logic     cfg_ready
);

  `BMM_ASSERT_NEXT(a_last_row_busy, start && !busy && item.last_row, busy, "no run after last row")
  `BMM_ASSERT_NEXT(a_strobe_single, strobe, !strobe, "results back to back")
  `BMM_ASSERT_SAME(a_unmatched_zero, strobe && !result.is_matched, result.left_partner == '0, "unmatched partner not zero")
  `BMM_ASSERT_SAME(a_next_result, strobe && !result.last_result, ##3 (strobe && result.right_index == $past(result.right_index, 3) + 6'd1 && result.matched_total == $past(result.matched_total, 3)), "result sequence broken")
  `BMM_ASSERT_SAME(a_cfg_idle, busy, !cfg_ready, "config open while busy")

endmodule

bind bipartite_max_matching_core bmm_checker u_bmm_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .item      (item),
  .strobe    (strobe),
  .result    (result),
  .cfg_ready (cfg_ready)
);
